[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[sv/itda_pkg.sv]
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types, constants and functions of the decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_WIDTH   = 4 * NUM_DIGITS;

   localparam logic [3:0] CONV_LAST   = 4'd15;   // two bits per step, 16 steps
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture a new word and clear the BCD register
      logic shift;   // one double-dabble step (two bits)
      logic count;   // register digit count and emit pointer
      logic emit;    // load the next character into the output register
   } itda_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic conv_done;   // last conversion step in progress
      logic emit_last;   // next character is the final one
      logic slot_free;   // output register can take a character
   } itda_sts_type;

   // One double-dabble bit: add 3 to every digit of 5 or more, then shift in.
   function automatic logic [BCD_WIDTH-1:0] dabble(input logic [BCD_WIDTH-1:0] bcd,
                                                   input logic                 din);
      logic [BCD_WIDTH-1:0] adj;
      logic [3:0]           nib;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         nib = bcd[i*4 +: 4];
         adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
      return {adj[BCD_WIDTH-2:0], din};
   endfunction

   // Number of significant digits, at least one.
   function automatic logic [3:0] digit_count(input logic [BCD_WIDTH-1:0] bcd);
      logic [3:0] n;
      n = 4'd1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

[sv/itda_dp.sv]
// ----------------------------------------------------------------------------
// itda_dp
// Datapath: magnitude, double-dabble BCD register, emit pointer, output reg.
// ----------------------------------------------------------------------------
module itda_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  itda_pkg::itda_cmd_type cmd,
   output itda_pkg::itda_sts_type sts,
   input  logic [31:0]            req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic [3:0]             rsp_tuser
);
   import itda_pkg::*;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   minus_ff, minus_in;
   logic [3:0]             pos_ff, pos_in;
   logic [3:0]             total_ff, total_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;
   logic [3:0]             ccount_ff, ccount_in;

   logic                   neg_word;
   logic [3:0]             nd;
   logic [3:0]             digit;

   assign neg_word = req_tuser & req_tdata[VALUE_WIDTH-1];
   assign nd       = digit_count(bcd_ff);
   assign digit    = bcd_ff[{pos_ff, 2'b00} +: 4];

   assign sts.conv_done = (cnt_ff == CONV_LAST);
   assign sts.emit_last = !minus_ff && (pos_ff == 4'd0);
   assign sts.slot_free = !valid_ff || rsp_tready;

   always_comb begin
      mag_in    = mag_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      minus_in  = minus_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      valid_in  = valid_ff & ~rsp_tready;
      char_in   = char_ff;
      last_in   = last_ff;
      ccount_in = ccount_ff;
      if (cmd.load) begin
         mag_in = neg_word ? (~req_tdata + 32'd1) : req_tdata;
         neg_in = neg_word;
         bcd_in = '0;
         cnt_in = 4'd0;
      end
      if (cmd.shift) begin
         bcd_in = dabble(dabble(bcd_ff, mag_ff[VALUE_WIDTH-1]), mag_ff[VALUE_WIDTH-2]);
         mag_in = {mag_ff[VALUE_WIDTH-3:0], 2'b00};
         cnt_in = cnt_ff + 4'd1;
      end
      if (cmd.count) begin
         pos_in   = nd - 4'd1;
         minus_in = neg_ff;
         total_in = nd + {3'b000, neg_ff};
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         if (minus_ff) begin
            char_in   = ASCII_MINUS;
            last_in   = 1'b0;
            ccount_in = 4'd0;
            minus_in  = 1'b0;
         end else begin
            char_in   = ASCII_ZERO + {4'd0, digit};
            last_in   = (pos_ff == 4'd0);
            ccount_in = (pos_ff == 4'd0) ? total_ff : 4'd0;
            pos_in    = pos_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff    <= mag_in;
      bcd_ff    <= bcd_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      minus_ff  <= minus_in;
      pos_ff    <= pos_in;
      total_ff  <= total_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      ccount_ff <= ccount_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = ccount_ff;

endmodule

[sv/itda_ctrl.sv]
// ----------------------------------------------------------------------------
// itda_ctrl
// Controller: sequences load, conversion, digit count and character emit.
// ----------------------------------------------------------------------------
module itda_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  itda_pkg::itda_sts_type sts,
   output itda_pkg::itda_cmd_type cmd
);
   import itda_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/int_to_decimal_ascii_top.sv]
// Flow: each accepted word runs the 16-step two-bit double-dabble loop, a
// digit count step, then one character per cycle through the output register
// while the result side is ready; a number has 1 to 11 characters. A new word
// is taken only once the final character of the last one is in the register.
// Reset: synchronous, active high; clears the controller and output valid.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Prints a 32-bit word as decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module int_to_decimal_ascii_top (
   input  logic        clock,
   input  logic        reset,
   // input word channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] opcode: 0 unsigned, 1 signed
   // character channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] character
   output logic        rsp_tlast,   // final character of the number
   output logic [3:0]  rsp_tuser    // [3:0] char_count, zero unless tlast
);
   import itda_pkg::*;

   itda_cmd_type cmd;
   itda_sts_type sts;

   // Controller: accept a word, run the conversion, then emit characters
   // whenever the output register is free or being drained.
   itda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: negate signed negatives, convert to BCD two bits per cycle,
   // count significant digits, then walk digits down from the top.
   itda_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A transfer in starts a conversion: the input side must drop ready.
   `ASSERT_PROP(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "input accepted while converting")
   // Final character always carries a nonzero count.
   `ASSERT_PROP(a_last_count, clock, reset, (rsp_tvalid && rsp_tlast) |-> (rsp_tuser != 4'd0), "last character with zero count")
   // Non-final characters carry a zero count.
   `ASSERT_PROP(a_mid_count, clock, reset, (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == 4'd0), "count on non-final character")
   // A minus sign never ends a number.
   `ASSERT_NEVER(a_minus_last, clock, reset, rsp_tvalid && rsp_tlast && (rsp_tdata == ASCII_MINUS), "minus as final character")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds 32-bit words, unsigned and signed, into the decimal ASCII converter
// and checks every character that comes back, in order, against a predicted
// character stream. Both the word sender and the character receiver pause at
// random.
// ----------------------------------------------------------------------------
module testbench;

   // opcode carried in req_tuser
   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   localparam int IDLE_PERCENT   = 22;
   localparam int RANDOM_WORDS   = 130;
   localparam int CALM_WORDS     = 40;     // leading random words with no pauses
   localparam int DRAIN_EVERY    = 50;
   localparam int SETTLE_CYCLES  = 40;     // settling wait after the final drain
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic [3:0] count;
   } ascii_char_type;

   // Predicts the text of each accepted word and checks the characters.
   class decimal_text_board;
      ascii_char_type expected_chars[$];
      int             mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // Spell a word as decimal text, most significant digit first.
      function void note_word(logic [31:0] value, logic opcode);
         logic           negative;
         logic [31:0]    magnitude;
         logic [3:0]     digits[10];
         int             num_digits;
         int             total;
         ascii_char_type c;
         negative   = (opcode == OP_SIGNED) && value[31];
         magnitude  = negative ? -value : value;
         num_digits = 0;
         do begin
            digits[num_digits] = 4'(magnitude % 32'd10);
            magnitude          = magnitude / 32'd10;
            num_digits++;
         end while (magnitude != 0);
         total = num_digits + (negative ? 1 : 0);
         if (negative) begin
            c = '{character: itda_pkg::ASCII_MINUS, last: 1'b0, count: 4'd0};
            expected_chars.push_back(c);
         end
         for (int i = num_digits - 1; i >= 0; i--) begin
            c.character = itda_pkg::ASCII_ZERO + 8'(digits[i]);
            c.last      = (i == 0);
            c.count     = (i == 0) ? 4'(total) : 4'd0;
            expected_chars.push_back(c);
         end
      endfunction

      function void check_char(logic [7:0] character, logic last, logic [3:0] count);
         ascii_char_type exp;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character %h last %b count %0d", $time,
                     character, last, count);
            mismatches++;
            return;
         end
         exp = expected_chars.pop_front();
         if (character !== exp.character || last !== exp.last || count !== exp.count) begin
            $display("%0t: mismatch, expected char %h last %b count %0d,", $time,
                     exp.character, exp.last, exp.count,
                     " actual char %h last %b count %0d", character, last, count);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic        req_tuser;   // [0] opcode: 0 unsigned, 1 signed
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] character
   logic        rsp_tlast;   // final character of the number
   logic [3:0]  rsp_tuser;   // [3:0] char_count, zero unless tlast

   decimal_text_board board;
   logic              idle_on;     // random pauses on both sides
   int                quiet_cycles;

   int_to_decimal_ascii_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record every transfer at the rising edge: words first, then characters.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_word(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_char(rsp_tdata, rsp_tlast, rsp_tuser);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Receiver: drop tready at random while pauses are on, hold it high otherwise.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (idle_on) begin
            rsp_tready = ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Present one word and hold it until the transfer; returns at a falling edge.
   task automatic send_word(input logic [31:0] value, input logic opcode);
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         req_tdata  = $urandom();
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = opcode;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the sender until every predicted character has come back.
   task automatic wait_for_text;
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Draw a word shaped to spread the digit count and the sign.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $urandom_range(0, 99);
         2:       return $urandom() >> $urandom_range(0, 31);
         default: return -32'($urandom_range(1, 1000));
      endcase
   endfunction

   initial begin
      board        = new();
      reset        = 1'b1;
      idle_on      = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_UNSIGNED;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words: zero both ways, digit-count boundaries, all-ones,
      // the most negative value, and alternating bit patterns.
      send_word(32'd0,          OP_UNSIGNED);
      send_word(32'd0,          OP_SIGNED);
      send_word(32'd1,          OP_UNSIGNED);
      send_word(32'd9,          OP_SIGNED);
      send_word(32'd10,         OP_UNSIGNED);
      send_word(32'd99,         OP_UNSIGNED);
      send_word(32'd100,        OP_SIGNED);
      send_word(32'd999999999,  OP_SIGNED);
      send_word(32'd1000000000, OP_UNSIGNED);
      send_word(32'hFFFFFFFF,   OP_UNSIGNED);
      send_word(32'hFFFFFFFF,   OP_SIGNED);
      send_word(32'h80000000,   OP_SIGNED);
      send_word(32'h80000000,   OP_UNSIGNED);
      send_word(32'h7FFFFFFF,   OP_SIGNED);
      send_word(32'hFFFFFFF6,   OP_SIGNED);
      send_word(32'd4000000000, OP_UNSIGNED);
      send_word(32'd123456789,  OP_SIGNED);
      send_word(32'hAAAAAAAA,   OP_UNSIGNED);
      send_word(32'hAAAAAAAA,   OP_SIGNED);
      send_word(32'h55555555,   OP_UNSIGNED);
      send_word(32'h55555555,   OP_SIGNED);
      wait_for_text();

      // Random words: a calm stretch first, then pauses on both sides.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         idle_on = (n >= CALM_WORDS);
         send_word(pick_value(), 1'($urandom_range(1)));
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            wait_for_text();
         end
      end

      wait_for_text();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0t: %0d characters never arrived", $time, board.pending());
      end
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/itda_pkg.sv
sv/itda_dp.sv
sv/itda_ctrl.sv
sv/int_to_decimal_ascii_top.sv
tb/sv/testbench.sv
